### hw/rtl/hann_window_2d_apply_top_assert.svh
// ----------------------------------------------------------------------------
// Hann window assertion macros
// Shorthand for the clocked checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HANN_WINDOW_2D_APPLY_TOP_ASSERT_SVH
`define HANN_WINDOW_2D_APPLY_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HWA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hann window check failed");

// Next-cycle implication, disabled during reset.
`define HWA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hann window check failed");

`endif

### hw/rtl/hwa_pkg.sv
// ----------------------------------------------------------------------------
// hwa_pkg
// Shared constants, types and Taylor coefficient tables of the Hann window.
// ----------------------------------------------------------------------------
package hwa_pkg;

    localparam int DEF_MAX_COLS         = 4096;
    localparam int DEF_MAX_ROWS         = 4096;
    localparam int DEF_SAMPLE_BITS      = 24;
    localparam int DEF_WEIGHT_FRAC_BITS = 16;

    localparam int CFG_BITS  = 13;
    localparam int LEN_BITS  = 17;
    localparam int ANG_BITS  = 31;
    localparam int NUM_BITS  = 32 + LEN_BITS;
    localparam int DEN_BITS  = LEN_BITS + 1;
    localparam int NUM_CELLS = 6;
    localparam int SIN_TERMS = 5;

    localparam logic [31:0]         PI_Q30  = 32'd3373259426;
    localparam logic [ANG_BITS-1:0] ONE_Q30 = ANG_BITS'(1) << 30;

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } hwa_reg_t;

    // One step of the Taylor series as it moves along the cell row.
    typedef struct packed
    {
        logic                       valid;
        logic                       sin_mode;
        logic [ANG_BITS-1:0]        x2;
        logic [ANG_BITS-1:0]        term;
        logic signed [ANG_BITS+1:0] sum;
    } hwa_chain_t;

    // Integer factorial step of term idx (1-based).
    function automatic logic [7:0] taylor_div(input int idx, input logic sin_mode);
        int d;
        begin
            if (sin_mode)
            begin
                d = (2 * idx) * (2 * idx + 1);
            end
            else
            begin
                d = (2 * idx - 1) * (2 * idx);
            end
            return 8'(d);
        end
    endfunction

    // floor(2^32 / taylor_div(idx, sin_mode))
    function automatic logic [31:0] taylor_recip(input int idx, input logic sin_mode);
        logic [31:0] r;
        begin
            r = 32'd1;
            if (sin_mode)
            begin
                unique case (idx)
                    1:       r = 32'd715827882;
                    2:       r = 32'd214748364;
                    3:       r = 32'd102261126;
                    4:       r = 32'd59652323;
                    5:       r = 32'd39045157;
                    default: r = 32'd1;
                endcase
            end
            else
            begin
                unique case (idx)
                    1:       r = 32'd2147483648;
                    2:       r = 32'd357913941;
                    3:       r = 32'd143165576;
                    4:       r = 32'd76695844;
                    5:       r = 32'd47721858;
                    6:       r = 32'd32537631;
                    default: r = 32'd1;
                endcase
            end
            return r;
        end
    endfunction

endpackage

### hw/rtl/hwa_taylor_cell.sv
// ----------------------------------------------------------------------------
// hwa_taylor_cell
// One Taylor term: term*x2 >> 30, divide by the factorial step, accumulate.
// ----------------------------------------------------------------------------
module hwa_taylor_cell
    import hwa_pkg::*;
#(
    parameter int IDX = 1
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  hwa_chain_t din,
    output hwa_chain_t dout
);

    localparam logic [7:0]  D_SIN  = taylor_div(IDX, 1'b1);
    localparam logic [7:0]  D_COS  = taylor_div(IDX, 1'b0);
    localparam logic [31:0] R_SIN  = taylor_recip(IDX, 1'b1);
    localparam logic [31:0] R_COS  = taylor_recip(IDX, 1'b0);
    localparam logic        ODD    = (IDX % 2) == 1;
    localparam logic        SIN_ON = IDX <= SIN_TERMS;

    // stage 1: product with x^2
    logic                       v1_reg;
    logic                       m1_reg;
    logic [ANG_BITS-1:0]        x2_1_reg;
    logic [ANG_BITS-1:0]        t1_reg;
    logic signed [ANG_BITS+1:0] s1_reg;
    logic [ANG_BITS-1:0]        p1_reg;
    // stage 2: reciprocal estimate
    logic                       v2_reg;
    logic                       m2_reg;
    logic [ANG_BITS-1:0]        x2_2_reg;
    logic [ANG_BITS-1:0]        t2_reg;
    logic signed [ANG_BITS+1:0] s2_reg;
    logic [ANG_BITS-1:0]        p2_reg;
    logic [ANG_BITS-1:0]        est_reg;
    // stage 3: corrected quotient and running sum
    logic                       v3_reg;
    logic                       m3_reg;
    logic [ANG_BITS-1:0]        x2_3_reg;
    logic [ANG_BITS-1:0]        t3_reg;
    logic signed [ANG_BITS+1:0] s3_reg;

    logic [2*ANG_BITS-1:0]      mul1;
    logic [ANG_BITS-1:0]        p1_next;
    logic [31:0]                recip;
    logic [ANG_BITS+31:0]       mul2;
    logic [ANG_BITS-1:0]        est_next;
    logic [7:0]                 dv;
    logic [ANG_BITS+7:0]        back;
    logic [ANG_BITS+7:0]        remv;
    logic [ANG_BITS-1:0]        q;
    logic                       active;
    logic [ANG_BITS-1:0]        t3_next;
    logic signed [ANG_BITS+1:0] s3_next;

    always_comb
    begin
        mul1     = (2*ANG_BITS)'(din.term) * (2*ANG_BITS)'(din.x2);
        p1_next  = mul1[ANG_BITS+29:30];
        recip    = m1_reg ? R_SIN : R_COS;
        mul2     = (ANG_BITS+32)'(p1_reg) * (ANG_BITS+32)'(recip);
        est_next = mul2[ANG_BITS+31:32];
        dv       = m2_reg ? D_SIN : D_COS;
        back     = (ANG_BITS+8)'(est_reg) * (ANG_BITS+8)'(dv);
        remv     = (ANG_BITS+8)'(p2_reg) - back;
        q        = (remv >= (ANG_BITS+8)'(dv)) ? est_reg + ANG_BITS'(1) : est_reg;
        active   = !m2_reg || SIN_ON;
        t3_next  = active ? q : t2_reg;
        if (!active)
        begin
            s3_next = s2_reg;
        end
        else if (ODD)
        begin
            s3_next = s2_reg - $signed((ANG_BITS+2)'(q));
        end
        else
        begin
            s3_next = s2_reg + $signed((ANG_BITS+2)'(q));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= din.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg   <= din.sin_mode;
        x2_1_reg <= din.x2;
        t1_reg   <= din.term;
        s1_reg   <= din.sum;
        p1_reg   <= p1_next;
        m2_reg   <= m1_reg;
        x2_2_reg <= x2_1_reg;
        t2_reg   <= t1_reg;
        s2_reg   <= s1_reg;
        p2_reg   <= p1_reg;
        est_reg  <= est_next;
        m3_reg   <= m2_reg;
        x2_3_reg <= x2_2_reg;
        t3_reg   <= t3_next;
        s3_reg   <= s3_next;
    end

    assign dout.valid    = v3_reg;
    assign dout.sin_mode = m3_reg;
    assign dout.x2       = x2_3_reg;
    assign dout.term     = t3_reg;
    assign dout.sum      = s3_reg;

endmodule

### hw/rtl/hwa_taylor_chain.sv
// ----------------------------------------------------------------------------
// hwa_taylor_chain
// Row of Taylor cells; sin uses the first five terms, cos all six.
// ----------------------------------------------------------------------------
module hwa_taylor_chain
    import hwa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hwa_chain_t din,
    output hwa_chain_t dout
);

    hwa_chain_t link [0:NUM_CELLS];

    assign link[0] = din;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        hwa_taylor_cell #(
            .IDX (i + 1)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (link[i]),
            .dout  (link[i+1])
        );
    end

    assign dout = link[NUM_CELLS];

endmodule

### hw/rtl/hann_window_2d_apply_top.sv
// One sample at a time: the next sample is taken once the current one has left the weight
// path, and a stalled output holds it there. The 49-step angle divider and the 18-stage
// Taylor cell row each run once for the column and once for the row factor of a sample.
// Reset: frame size returns to 256 x 256, position to row 0, column 0.
// ----------------------------------------------------------------------------
// hann_window_2d_apply_top
// Raster-order 2-D Hann window: each sample times sin^2 column and row
// weights made on the fly with a fixed-point Taylor evaluator.
// ----------------------------------------------------------------------------
module hann_window_2d_apply_top
    import hwa_pkg::*;
#(
    parameter int MAX_COLS         = DEF_MAX_COLS,
    parameter int MAX_ROWS         = DEF_MAX_ROWS,
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [CFG_BITS-1:0]           cfg_data,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] windowed_sample,
    output logic                          row_end,
    output logic                          frame_end
);

    localparam int F   = WEIGHT_FRAC_BITS;
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int WB  = F + 1;                 // weight, at most 1.0
    localparam int PB  = SAMPLE_BITS + WB + 1;  // signed product
    localparam int CNB = $clog2(NUM_BITS + 1);

    // One-hot sequencer. Column factor first (sel 0), then row factor (sel 1).
    typedef enum logic [9:0]
    {
        ST_IDLE = 10'b00_0000_0001,
        ST_PREP = 10'b00_0000_0010,  // fold position, build angle fraction
        ST_DIV  = 10'b00_0000_0100,  // restoring divide, one bit per cycle
        ST_SQX  = 10'b00_0000_1000,  // x^2 in Q30
        ST_GO   = 10'b00_0001_0000,  // launch into the cell row
        ST_WAIT = 10'b00_0010_0000,  // wait for the row to drain
        ST_SQR  = 10'b00_0100_0000,  // square and round to the factor
        ST_WGT  = 10'b00_1000_0000,  // column factor times row factor
        ST_MUL  = 10'b01_0000_0000,  // sample times weight
        ST_DONE = 10'b10_0000_0000   // hand over to the output register
    } state_t;

    state_t state_reg, state_next;

    // configuration and position
    logic [CFG_BITS-1:0] frame_width_reg;
    logic [CFG_BITS-1:0] frame_height_reg;
    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;

    // per-item payload
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          rend_reg;
    logic                          fend_reg;
    logic [LEN_BITS-1:0]           k_reg [0:1];
    logic [LEN_BITS-1:0]           m_reg [0:1];
    logic                          sel_reg, sel_next;
    logic                          sin_reg;
    logic [NUM_BITS-1:0]           num_reg;
    logic [DEN_BITS-1:0]           den_reg;
    logic [DEN_BITS-1:0]           rem_reg;
    logic [ANG_BITS-1:0]           quot_reg;
    logic [CNB-1:0]                cnt_reg, cnt_next;
    logic [ANG_BITS-1:0]           x2_reg;
    logic [ANG_BITS-1:0]           s_reg;
    logic [WB-1:0]                 fac_reg [0:1];
    logic [WB-1:0]                 weight_reg;
    logic [SAMPLE_BITS-1:0]        res_reg;

    // output register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_rend_reg;
    logic                          out_fend_reg;

    // accept-time position logic
    logic                in_acc;
    logic [LEN_BITS-1:0] fw_ext, fh_ext, w_eff, h_eff, m_col, m_row;
    logic [LEN_BITS-1:0] col_ext, row_ext, col_c, row_c;
    logic                rend, fend;

    // angle fraction
    logic [LEN_BITS-1:0] k_sel, m_sel, mk, kr;
    logic                sinb;
    logic [NUM_BITS-1:0] num_next;
    logic [DEN_BITS-1:0] den_next;

    // divider step
    logic [DEN_BITS:0]   trial;
    logic                ge;
    logic [DEN_BITS-1:0] rem_step;

    // Taylor row
    hwa_chain_t chain_in, chain_out;

    // arithmetic after the row
    logic [2*ANG_BITS-1:0] xsq;
    logic [ANG_BITS-1:0]   s_clamp;
    logic [2*ANG_BITS-1:0] ssq, ssq_rnd, f_full;
    logic [WB-1:0]         f_cap;
    logic [2*WB-1:0]       wprod;
    logic signed [PB-1:0]  prod, prod_rnd, prod_sh;

    logic out_free;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign out_free = !out_valid_reg || !out_stall;

    // effective lengths and clamped positions
    always_comb
    begin
        fw_ext = LEN_BITS'(frame_width_reg);
        fh_ext = LEN_BITS'(frame_height_reg);
        priority if (fw_ext < LEN_BITS'(2))
            w_eff = LEN_BITS'(2);
        else if (fw_ext > LEN_BITS'(MAX_COLS))
            w_eff = LEN_BITS'(MAX_COLS);
        else
            w_eff = fw_ext;
        priority if (fh_ext < LEN_BITS'(2))
            h_eff = LEN_BITS'(2);
        else if (fh_ext > LEN_BITS'(MAX_ROWS))
            h_eff = LEN_BITS'(MAX_ROWS);
        else
            h_eff = fh_ext;
        m_col   = w_eff - LEN_BITS'(1);
        m_row   = h_eff - LEN_BITS'(1);
        col_ext = LEN_BITS'(col_reg);
        row_ext = LEN_BITS'(row_reg);
        // a position past the end (size lowered mid-frame) counts as the last
        col_c   = (col_ext > m_col) ? m_col : col_ext;
        row_c   = (row_ext > m_row) ? m_row : row_ext;
        rend    = col_c == m_col;
        fend    = rend && (row_c == m_row);
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc)
        begin
            if (rend)
            begin
                col_next = '0;
                row_next = fend ? '0 : RW'(row_c + LEN_BITS'(1));
            end
            else
            begin
                col_next = CW'(col_c + LEN_BITS'(1));
                row_next = RW'(row_c);
            end
        end
    end

    // Fold k into the first quarter: sin(pi*k/m) for the outer quarters of k,
    // cos(pi*(m-2k)/(2m)) near the middle.
    always_comb
    begin
        k_sel = k_reg[sel_reg];
        m_sel = m_reg[sel_reg];
        mk    = m_sel - k_sel;
        kr    = (k_sel <= mk) ? k_sel : mk;
        sinb  = {kr, 2'b00} <= {2'b00, m_sel};
        if (sinb)
        begin
            num_next = NUM_BITS'(PI_Q30) * NUM_BITS'(kr) + NUM_BITS'(m_sel >> 1);
            den_next = DEN_BITS'(m_sel);
        end
        else
        begin
            num_next = NUM_BITS'(PI_Q30) * NUM_BITS'(m_sel - {kr[LEN_BITS-2:0], 1'b0})
                     + NUM_BITS'(m_sel);
            den_next = {m_sel, 1'b0};
        end
    end

    always_comb
    begin
        trial    = {rem_reg, num_reg[NUM_BITS-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_step = ge ? DEN_BITS'(trial - {1'b0, den_reg}) : DEN_BITS'(trial);
    end

    always_comb
    begin
        chain_in.valid    = state_reg == ST_GO;
        chain_in.sin_mode = sin_reg;
        chain_in.x2       = x2_reg;
        chain_in.term     = sin_reg ? quot_reg : ONE_Q30;
        chain_in.sum      = $signed((ANG_BITS+2)'(sin_reg ? quot_reg : ONE_Q30));
    end

    hwa_taylor_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (chain_in),
        .dout  (chain_out)
    );

    always_comb
    begin
        xsq = (2*ANG_BITS)'(quot_reg) * (2*ANG_BITS)'(quot_reg);
        priority if (chain_out.sum < 0)
            s_clamp = '0;
        else if (chain_out.sum > $signed((ANG_BITS+2)'(ONE_Q30)))
            s_clamp = ONE_Q30;
        else
            s_clamp = chain_out.sum[ANG_BITS-1:0];
        ssq     = (2*ANG_BITS)'(s_reg) * (2*ANG_BITS)'(s_reg);
        ssq_rnd = ssq + ((2*ANG_BITS)'(1) << (59 - F));
        f_full  = ssq_rnd >> (60 - F);
        f_cap   = (f_full > ((2*ANG_BITS)'(1) << F)) ? (WB'(1) << F) : WB'(f_full);
        wprod   = (2*WB)'(fac_reg[0]) * (2*WB)'(fac_reg[1])
                + ((2*WB)'(1) << (F - 1));
        prod     = PB'(sample_reg) * $signed({1'b0, weight_reg});
        prod_rnd = prod + $signed(PB'(1) << (F - 1));
        prod_sh  = prod_rnd >>> F;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_PREP;
                    sel_next   = 1'b0;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
                cnt_next   = CNB'(NUM_BITS);
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - CNB'(1);
                if (cnt_reg == CNB'(1))
                    state_next = ST_SQX;
            end
            ST_SQX:  state_next = ST_GO;
            ST_GO:   state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (chain_out.valid)
                    state_next = ST_SQR;
            end
            ST_SQR:
            begin
                if (sel_reg)
                begin
                    state_next = ST_WGT;
                end
                else
                begin
                    sel_next   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_WGT:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sel_reg          <= 1'b0;
            cnt_reg          <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
            frame_width_reg  <= CFG_BITS'(256);
            frame_height_reg <= CFG_BITS'(256);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sample_reg <= sample;
            rend_reg   <= rend;
            fend_reg   <= fend;
            k_reg[0]   <= col_c;
            k_reg[1]   <= row_c;
            m_reg[0]   <= m_col;
            m_reg[1]   <= m_row;
        end
        if (state_reg == ST_PREP)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
            rem_reg <= '0;
            sin_reg <= sinb;
        end
        if (state_reg == ST_DIV)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= rem_step;
            quot_reg <= {quot_reg[ANG_BITS-2:0], ge};
        end
        if (state_reg == ST_SQX)
            x2_reg <= xsq[ANG_BITS+29:30];
        if (state_reg == ST_WAIT && chain_out.valid)
            s_reg <= s_clamp;
        if (state_reg == ST_SQR)
            fac_reg[sel_reg] <= f_cap;
        if (state_reg == ST_WGT)
            weight_reg <= WB'(wprod >> F);
        if (state_reg == ST_MUL)
            res_reg <= prod_sh[SAMPLE_BITS-1:0];
        if (state_reg == ST_DONE && out_free)
        begin
            out_sample_reg <= $signed(res_reg);
            out_rend_reg   <= rend_reg;
            out_fend_reg   <= fend_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign windowed_sample = out_sample_reg;
    assign row_end         = out_rend_reg;
    assign frame_end       = out_fend_reg;

`include "hann_window_2d_apply_top_assert.svh"

    // a new item always starts with the column factor
    `HWA_ASSERT_NEXT(a_start_col, in_acc, state_reg == ST_PREP && !sel_reg)
    // the cell row only delivers while the sequencer waits for it
    `HWA_ASSERT_NOW(a_chain_wait, chain_out.valid, state_reg == ST_WAIT)
    // the divider never runs with an exhausted step count
    `HWA_ASSERT_NOW(a_div_cnt, state_reg == ST_DIV, cnt_reg != '0)

endmodule

### tb/hann_window_2d_apply_checker.sv
// ----------------------------------------------------------------------------
// Hann window result checker
// Watches the config port and both item channels, predicts each windowed
// result from its own copy of the frame size and position, and compares.
// ----------------------------------------------------------------------------
module hann_window_2d_apply_checker
    import hwa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic signed [23:0]  sample,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic signed [23:0]  windowed_sample,
    input  logic                row_end,
    input  logic                frame_end,
    output int                  errors,
    output int                  pending
);

    typedef struct packed
    {
        logic signed [23:0] value;
        logic               row_last;
        logic               frame_last;
    } windowed_t;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    windowed_t   windowed_q[$];
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    int unsigned col_pos;
    int unsigned row_pos;

    assign pending = windowed_q.size();

    function automatic longint unsigned sat_q30(input longint acc);
        if (acc < 0)
            return 0;
        if (acc > longint'(Q30_ONE))
            return Q30_ONE;
        return longint'(acc);
    endfunction

    function automatic longint unsigned sin_taylor(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int i = 1; i <= 5; i++)
        begin
            term = ((term * x2) >> 30) / ((2 * i) * (2 * i + 1));
            if (i % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        return sat_q30(acc);
    endfunction

    function automatic longint unsigned cos_taylor(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x2   = (x * x) >> 30;
        term = Q30_ONE;
        acc  = longint'(Q30_ONE);
        for (int i = 1; i <= 6; i++)
        begin
            term = ((term * x2) >> 30) / ((2 * i - 1) * (2 * i));
            if (i % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        return sat_q30(acc);
    endfunction

    // sin^2(pi*k/(n-1)), 16 fraction bits
    function automatic longint unsigned hann_gain(input longint unsigned k,
                                                  input longint unsigned n);
        longint unsigned m;
        longint unsigned kr;
        longint unsigned s;
        longint unsigned f;
        m  = n - 1;
        kr = (k <= m - k) ? k : m - k;
        if (4 * kr <= m)
            s = sin_taylor((longint'(PI_Q30) * kr + m / 2) / m);
        else
            s = cos_taylor((longint'(PI_Q30) * (m - 2 * kr) + m) / (2 * m));
        f = (s * s + (64'd1 << 43)) >> 44;
        if (f > 64'd65536)
            f = 64'd65536;
        return f;
    endfunction

    function automatic int unsigned clamp_len(input logic [12:0] v);
        if (v < 2)
            return 2;
        if (v > 4096)
            return 4096;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        windowed_t       exp_item;
        windowed_t       got;
        int unsigned     w;
        int unsigned     h;
        int unsigned     col;
        int unsigned     row;
        longint unsigned weight;
        longint          prod;
        if (!rst_n)
        begin
            windowed_q.delete();
            width_reg  = 13'd256;
            height_reg = 13'd256;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{windowed_sample, row_end, frame_end};
                if (windowed_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual %p", $time, got);
                end
                else
                begin
                    exp_item = windowed_q.pop_front();
                    if (got.value !== exp_item.value)
                    begin
                        errors++;
                        $display("%0t: windowed_sample expected %0d actual %0d",
                                 $time, exp_item.value, got.value);
                    end
                    if (got.row_last !== exp_item.row_last)
                    begin
                        errors++;
                        $display("%0t: row_end expected %0b actual %0b",
                                 $time, exp_item.row_last, got.row_last);
                    end
                    if (got.frame_last !== exp_item.frame_last)
                    begin
                        errors++;
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, exp_item.frame_last, got.frame_last);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                w   = clamp_len(width_reg);
                h   = clamp_len(height_reg);
                col = (col_pos > w - 1) ? w - 1 : col_pos;
                row = (row_pos > h - 1) ? h - 1 : row_pos;
                exp_item.row_last   = (col == w - 1);
                exp_item.frame_last = exp_item.row_last && (row == h - 1);
                weight = (hann_gain(col, w) * hann_gain(row, h) + 64'd32768) >> 16;
                prod   = longint'(sample) * longint'(weight) + 32768;
                exp_item.value = 24'(prod >>> 16);
                windowed_q.push_back(exp_item);
                if (exp_item.row_last)
                begin
                    col_pos = 0;
                    row_pos = exp_item.frame_last ? 0 : ((row + 1) & 12'hFFF);
                end
                else
                begin
                    col_pos = (col + 1) & 12'hFFF;
                    row_pos = row;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
        end
    end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Hann window regression bench
// Drives samples through several frame sizes with random idling and one long
// receiver hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import hwa_pkg::*;

    localparam int LATENCY     = 150;      // a little longer than the weight path
    localparam int CYCLE_LIMIT = 1000000;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_BITS-1:0] cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic signed [23:0]  sample;
    logic                out_valid;
    logic                out_stall;
    logic signed [23:0]  windowed_sample;
    logic                row_end;
    logic                frame_end;
    int                  errors;
    int                  pending;

    // control of the receiver process
    bit                  no_idle;
    bit                  hold_go;
    bit                  hold_done;
    int                  hold_left;
    int                  cycles;
    int                  items_sent;

    hann_window_2d_apply_top uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .windowed_sample (windowed_sample),
        .row_end         (row_end),
        .frame_end       (frame_end)
    );

    hann_window_2d_apply_checker chk
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .windowed_sample (windowed_sample),
        .row_end         (row_end),
        .frame_end       (frame_end),
        .errors          (errors),
        .pending         (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("hann_window_2d_apply_top regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off once requested so the
    // block backs up and stalls its input while the sender keeps offering.
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (no_idle)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 37);
    end

    // Mostly full-range random samples, with the extremes mixed in.
    function automatic logic [23:0] pick_sample();
        case ($urandom_range(9))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // Offer one item and hold it until accepted; idle gaps go before it.
    task automatic send_item(input logic [23:0] value);
        if (!no_idle)
        begin
            while ($urandom_range(99) < 37)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Register writes only with the block drained.
    task automatic write_reg(input hwa_reg_t idx, input logic [CFG_BITS-1:0] value);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_frame(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h,
                             input int count);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        repeat (count) send_item(pick_sample());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = '0;
        out_stall = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset size, a few extremes at the first corner
        send_item(24'h800000);
        send_item(24'h7FFFFF);
        send_item(24'h000000);
        // lengths below 2 clamp to 2; the position left over is past the end
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd1);
        send_item(24'h7FFFFF);
        send_item(24'h800000);
        send_item(24'hFFFFFF);
        send_item(24'h000001);
        // 3x3: the center sample gets full weight
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        send_item(24'h123456);
        send_item(24'h7FFFFF);
        send_item(24'h800000);
        send_item(24'h7FFFFF);
        send_item(24'h800000);
        send_item(24'hFFFFFF);
        send_item(24'h000001);
        send_item(24'h7FFFFF);
        send_item(24'h800000);

        // random phases; the 5x4 frame runs with no idling at all
        no_idle = 1'b1;
        run_frame(13'd5, 13'd4, 150);
        no_idle = 1'b0;
        run_frame(13'd2, 13'd2, 100);
        // width above the maximum clamps to 4096
        run_frame(13'h1FFF, 13'd2, 120);
        // lowering mid-frame puts the position past the end
        run_frame(13'd7, 13'd6, 150);
        run_frame(13'd4096, 13'd4096, 60);
        // the hold-off starts only once the sender is offering items again
        write_reg(REG_FRAME_WIDTH, 13'd17);
        write_reg(REG_FRAME_HEIGHT, 13'd9);
        hold_go = 1'b1;
        repeat (200) send_item(pick_sample());

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);

        $display("Sent %0d samples over frame sizes 2x2 through 4096x4096,", items_sent);
        $display("including clamped lengths, mid-frame resizing and a long output hold-off.");
        if (errors == 0)
            $display("hann_window_2d_apply_top regression: pass");
        else
            $display("hann_window_2d_apply_top regression: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/hwa_pkg.sv
hw/rtl/hwa_taylor_cell.sv
hw/rtl/hwa_taylor_chain.sv
hw/rtl/hann_window_2d_apply_top.sv
tb/hann_window_2d_apply_checker.sv
tb/testbench.sv
